### src/arnb_pkg.sv
// Package for the attack-release noise burst unit.
// Holds the fixed-point widths, reset values, register indexes, phase and controller
// types, and the command struct. It depends on nothing else.
package arnb_pkg;

  localparam int FRACTION_BITS = 24;
  localparam int SAMPLE_BITS   = 16;

  localparam int POLE_W  = FRACTION_BITS;
  localparam int OVS_W   = FRACTION_BITS - 3;
  localparam int LEVEL_W = FRACTION_BITS + 1;
  localparam int ENV_W   = FRACTION_BITS + 3;
  localparam int MUL_W   = FRACTION_BITS + 4;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = POLE_W;

  localparam logic [POLE_W-1:0] ATTACK_POLE_RST  = POLE_W'(15612244);
  localparam logic [POLE_W-1:0] RELEASE_POLE_RST = POLE_W'(15612244);
  localparam logic [OVS_W-1:0]  OVERSHOOT_RST    = OVS_W'(16777);

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_POLE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_POLE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_OVERSHOOT    = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_RELEASE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_WAIT,
    S_MUL_TGT,
    S_MUL_ENV,
    S_NORM,
    S_MUL_OUT,
    S_WRITE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    MS_TARGET,
    MS_ENVELOPE,
    MS_AUDIO
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_en;
    logic     norm_en;
    logic     out_load;
  } dp_cmd_t;

endpackage

### src/arnb_ctrl.sv
// Controller of the attack-release noise burst unit.
// Sequences the shared multiplier through one request and drives the handshakes.
// Depends on arnb_pkg.
module arnb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output arnb_pkg::dp_cmd_t cmd
);

  arnb_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic write_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arnb_pkg::S_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign write_ok = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_sel   = arnb_pkg::MS_TARGET;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      arnb_pkg::S_WAIT: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = arnb_pkg::S_MUL_TGT;
        end
      end
      arnb_pkg::S_MUL_TGT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = arnb_pkg::MS_TARGET;
        state_nxt   = arnb_pkg::S_MUL_ENV;
      end
      arnb_pkg::S_MUL_ENV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = arnb_pkg::MS_ENVELOPE;
        cmd.acc_en  = 1'b1;
        state_nxt   = arnb_pkg::S_NORM;
      end
      arnb_pkg::S_NORM: begin
        cmd.norm_en = 1'b1;
        state_nxt   = arnb_pkg::S_MUL_OUT;
      end
      arnb_pkg::S_MUL_OUT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = arnb_pkg::MS_AUDIO;
        state_nxt   = arnb_pkg::S_WRITE;
      end
      arnb_pkg::S_WRITE: begin
        if (write_ok) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = arnb_pkg::S_WAIT;
        end
      end
      default: state_nxt = arnb_pkg::S_WAIT;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

### src/arnb_dp.sv
// Datapath of the attack-release noise burst unit.
// Holds the envelope state, the shared multiplier with its accumulator and the
// output registers. Depends on arnb_pkg.
module arnb_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  arnb_pkg::dp_cmd_t                 cmd,
  input  logic                              gate,
  input  logic signed [arnb_pkg::SAMPLE_BITS-1:0] noise_sample,
  input  logic [arnb_pkg::POLE_W-1:0]       attack_pole,
  input  logic [arnb_pkg::POLE_W-1:0]       release_pole,
  input  logic [arnb_pkg::OVS_W-1:0]        overshoot,
  output logic signed [arnb_pkg::SAMPLE_BITS-1:0] audio_out,
  output logic [arnb_pkg::LEVEL_W-1:0]      envelope_level
);

  localparam int FB = arnb_pkg::FRACTION_BITS;
  localparam int SB = arnb_pkg::SAMPLE_BITS;
  localparam int EW = arnb_pkg::ENV_W;
  localparam int LW = arnb_pkg::LEVEL_W;
  localparam int PW = arnb_pkg::POLE_W;
  localparam int OW = arnb_pkg::OVS_W;
  localparam int MW = arnb_pkg::MUL_W;
  localparam int XW = arnb_pkg::PROD_W;
  localparam int AW = arnb_pkg::SUM_W;
  localparam int RW = AW - FB;

  localparam logic [LW-1:0] ONE_L = {1'b1, {FB{1'b0}}};
  localparam logic signed [EW-1:0] ONE_E = {{(EW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
  localparam logic signed [AW-1:0] HALF_A = {{(AW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
  localparam logic signed [RW-1:0] SAT_MAX = {{(RW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_MIN = {{(RW-SB+1){1'b1}}, {(SB-1){1'b0}}};

  arnb_pkg::phase_t phase_r, phase_nxt;
  logic prev_gate_r, prev_gate_nxt;
  logic signed [EW-1:0] env_r, env_nxt;
  logic [PW-1:0] pole_r, pole_nxt;
  logic signed [EW-1:0] target_r, target_nxt;
  logic signed [EW-1:0] level_r, level_nxt;
  logic signed [SB-1:0] noise_r;
  logic signed [XW-1:0] prod_r, acc_r;
  logic signed [SB-1:0] audio_r;
  logic [LW-1:0] lvl_out_r;

  logic signed [EW-1:0] ovs_ext, tgt_attack, tgt_release;
  logic [LW-1:0] one_minus_pole;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [XW-1:0] prod_full;
  logic signed [AW-1:0] step_sum, aud_sum;
  logic signed [EW-1:0] env_step;
  logic signed [RW-1:0] aud_wide;
  logic signed [SB-1:0] aud_sat;

  assign ovs_ext     = {{(EW-OW){1'b0}}, overshoot};
  assign tgt_attack  = ONE_E + ovs_ext;
  assign tgt_release = '0 - ovs_ext;

  assign one_minus_pole = ONE_L - {1'b0, pole_r};

  always_comb begin
    unique case (cmd.mul_sel)
      arnb_pkg::MS_TARGET: begin
        mul_a = {{(MW-LW){1'b0}}, one_minus_pole};
        mul_b = {{(MW-EW){target_r[EW-1]}}, target_r};
      end
      arnb_pkg::MS_ENVELOPE: begin
        mul_a = {{(MW-PW){1'b0}}, pole_r};
        mul_b = {{(MW-EW){env_r[EW-1]}}, env_r};
      end
      arnb_pkg::MS_AUDIO: begin
        mul_a = {{(MW-EW){level_r[EW-1]}}, level_r};
        mul_b = {{(MW-SB){noise_r[SB-1]}}, noise_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  assign step_sum = {acc_r[XW-1], acc_r} + {prod_r[XW-1], prod_r} + HALF_A;
  assign env_step = step_sum[FB+EW-1:FB];

  assign aud_sum  = {prod_r[XW-1], prod_r} + HALF_A;
  assign aud_wide = aud_sum[AW-1:FB];

  always_comb begin
    if (aud_wide > SAT_MAX) begin
      aud_sat = SAT_MAX[SB-1:0];
    end else if (aud_wide < SAT_MIN) begin
      aud_sat = SAT_MIN[SB-1:0];
    end else begin
      aud_sat = aud_wide[SB-1:0];
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    prev_gate_nxt = prev_gate_r;
    env_nxt       = env_r;
    pole_nxt      = pole_r;
    target_nxt    = target_r;
    level_nxt     = level_r;
    if (cmd.load_in) begin
      prev_gate_nxt = gate;
      if (gate && !prev_gate_r) begin
        phase_nxt  = arnb_pkg::PH_ATTACK;
        target_nxt = tgt_attack;
        pole_nxt   = attack_pole;
      end else if (!gate && prev_gate_r) begin
        phase_nxt  = arnb_pkg::PH_RELEASE;
        target_nxt = tgt_release;
        pole_nxt   = release_pole;
      end
    end
    if (cmd.norm_en) begin
      env_nxt = env_step;
      unique case (phase_r)
        arnb_pkg::PH_ATTACK: begin
          if (env_step >= ONE_E) begin
            env_nxt    = ONE_E;
            phase_nxt  = arnb_pkg::PH_RELEASE;
            target_nxt = tgt_release;
            pole_nxt   = release_pole;
          end
          level_nxt = env_nxt;
        end
        arnb_pkg::PH_RELEASE: begin
          if (env_step[EW-1] || env_step == '0) begin
            env_nxt   = '0;
            phase_nxt = arnb_pkg::PH_IDLE;
          end
          level_nxt = env_nxt;
        end
        default: level_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= arnb_pkg::PH_IDLE;
      prev_gate_r <= 1'b0;
      env_r       <= '0;
      pole_r      <= '0;
      target_r    <= '0;
    end else begin
      phase_r     <= phase_nxt;
      prev_gate_r <= prev_gate_nxt;
      env_r       <= env_nxt;
      pole_r      <= pole_nxt;
      target_r    <= target_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    if (cmd.load_in) begin
      noise_r <= noise_sample;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_full;
    end
    if (cmd.acc_en) begin
      acc_r <= prod_r;
    end
    if (cmd.out_load) begin
      audio_r   <= aud_sat;
      lvl_out_r <= level_r[LW-1:0];
    end
  end

  assign audio_out      = audio_r;
  assign envelope_level = lvl_out_r;

endmodule

### src/attack_release_noise_burst_unit.sv
// Top level of the attack-release noise burst unit.
// Holds the configuration registers and joins arnb_ctrl and arnb_dp.
// Depends on arnb_pkg, arnb_ctrl and arnb_dp.
//
// One request on the input stream is one audio sample tick: a gate bit and a
// signed noise sample. Each request yields exactly one result on the output
// stream: the noise sample scaled by the attack-release envelope, saturated to
// the sample width, together with the envelope level in Q24 form.
// The configuration channel writes the attack pole, the release pole and the
// target overshoot; it is always ready, and a write to an unknown index is
// dropped. New pole and overshoot values take effect at the next gate edge or at the end of an attack.
// A request passes through S_MUL_TGT, S_MUL_ENV, S_NORM, S_MUL_OUT and S_WRITE to the
// output register: one multiplier is shared by the three products of each tick, and
// the envelope update sits between them. The input is ready again as soon as the
// result is written, so no new request is taken before the last one is through.
// When the receiver stalls, the result stays in the output register and the
// next request is still accepted and worked on; it then waits for the slot.
// Reset clears the envelope and phase and restores the register defaults.
module attack_release_noise_burst_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [23:0]                        in_tdata,   // gate[0], noise_sample[16:1]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [47:0]                        out_tdata,  // audio_out[15:0], envelope_level[40:16]
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [arnb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [arnb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SB = arnb_pkg::SAMPLE_BITS;
  localparam int LW = arnb_pkg::LEVEL_W;

  logic [arnb_pkg::POLE_W-1:0] attack_pole_r, attack_pole_nxt;
  logic [arnb_pkg::POLE_W-1:0] release_pole_r, release_pole_nxt;
  logic [arnb_pkg::OVS_W-1:0]  overshoot_r, overshoot_nxt;

  arnb_pkg::dp_cmd_t cmd;
  logic signed [SB-1:0] audio_out;
  logic [LW-1:0]        envelope_level;

  assign cfg_ready = 1'b1;

  always_comb begin
    attack_pole_nxt  = attack_pole_r;
    release_pole_nxt = release_pole_r;
    overshoot_nxt    = overshoot_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        arnb_pkg::CFG_ATTACK_POLE:  attack_pole_nxt  = cfg_data;
        arnb_pkg::CFG_RELEASE_POLE: release_pole_nxt = cfg_data;
        arnb_pkg::CFG_OVERSHOOT:    overshoot_nxt    = cfg_data[arnb_pkg::OVS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_pole_r  <= arnb_pkg::ATTACK_POLE_RST;
      release_pole_r <= arnb_pkg::RELEASE_POLE_RST;
      overshoot_r    <= arnb_pkg::OVERSHOOT_RST;
    end else begin
      attack_pole_r  <= attack_pole_nxt;
      release_pole_r <= release_pole_nxt;
      overshoot_r    <= overshoot_nxt;
    end
  end

  arnb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  arnb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .gate           (in_tdata[0]),
    .noise_sample   (in_tdata[SB:1]),
    .attack_pole    (attack_pole_r),
    .release_pole   (release_pole_r),
    .overshoot      (overshoot_r),
    .audio_out      (audio_out),
    .envelope_level (envelope_level)
  );

  assign out_tdata = {{(48-SB-LW){1'b0}}, envelope_level, audio_out};

endmodule

### test/tb_top.sv
// Self-checking testbench for the attack-release noise burst unit.
// It predicts each result in SystemVerilog and checks the output stream against it.
// It depends on arnb_pkg and attack_release_noise_burst_unit.
module tb_top;
  import arnb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
  localparam longint UNITY = longint'(1) << FRACTION_BITS;
  localparam longint HALF_LSB = longint'(1) << (FRACTION_BITS - 1);
  localparam longint AUDIO_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint AUDIO_MIN = -(longint'(1) << (SAMPLE_BITS - 1));

  typedef struct {
    logic                   gate;
    logic [SAMPLE_BITS-1:0] noise;
  } sample_req_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] audio;
    logic [LEVEL_W-1:0]     level;
  } burst_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ATTACK_POLE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  attack_release_noise_burst_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sample_req_t   pending_q[$];
  burst_sample_t expected_q[$];
  int n_queued = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int n_cycles = 0;
  bit quiet = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int send_gap = 0;

  // Shadow registers and envelope state.
  logic [POLE_W-1:0] atk_pole = ATTACK_POLE_RST;
  logic [POLE_W-1:0] rel_pole = RELEASE_POLE_RST;
  logic [OVS_W-1:0]  ovs      = OVERSHOOT_RST;
  phase_t env_phase = PH_IDLE;
  logic   last_gate = 1'b0;
  longint env_q    = 0;
  longint pole_q   = 0;
  longint target_q = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void start_release();
    env_phase = PH_RELEASE;
    target_q  = 0 - longint'(ovs);
    pole_q    = longint'(rel_pole);
  endfunction

  function automatic burst_sample_t envelope_tick(input logic gate,
                                                  input logic signed [SAMPLE_BITS-1:0] noise);
    longint nz;
    longint lvl;
    longint aud;
    burst_sample_t r;
    nz  = noise;
    lvl = 0;
    aud = 0;
    if (gate && !last_gate) begin
      env_phase = PH_ATTACK;
      target_q  = UNITY + longint'(ovs);
      pole_q    = longint'(atk_pole);
    end else if (!gate && last_gate) begin
      start_release();
    end
    last_gate = gate;
    env_q = ((UNITY - pole_q) * target_q + pole_q * env_q + HALF_LSB) >>> FRACTION_BITS;
    if (env_phase == PH_ATTACK) begin
      if (env_q >= UNITY) begin
        env_q = UNITY;
        start_release();
      end
      lvl = env_q;
    end else if (env_phase == PH_RELEASE) begin
      if (env_q <= 0) begin
        env_q = 0;
        env_phase = PH_IDLE;
      end
      lvl = env_q;
    end
    if (lvl != 0) begin
      aud = (lvl * nz + HALF_LSB) >>> FRACTION_BITS;
      if (aud > AUDIO_MAX) aud = AUDIO_MAX;
      if (aud < AUDIO_MIN) aud = AUDIO_MIN;
    end
    r.audio = aud[SAMPLE_BITS-1:0];
    r.level = lvl[LEVEL_W-1:0];
    return r;
  endfunction

  // Idling is off for 64 accepted requests, then on for 128, in turn; quiet turns it off.
  function automatic bit idling_on();
    return !quiet && ((n_accepted >> 6) % 3 != 0);
  endfunction

  always @(posedge clk) begin : drive_requests
    sample_req_t nxt;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_q.push_back(envelope_tick(in_tdata[0], in_tdata[16:1]));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          nxt = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {7'b0, nxt.noise, nxt.gate};
          if (idling_on() && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 5);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off lets the block fill up and stall its input.
  always @(posedge clk) begin : hold_off
    if (rst_n) begin
      if (!hold_used && n_accepted >= 200) begin
        hold_used <= 1'b1;
        hold_left <= 150;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    burst_sample_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: tdata %h", out_tdata);
          n_errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[15:0] !== want.audio) begin
            $error("audio_out: expected %0d, actual %0d",
                   $signed(want.audio), $signed(out_tdata[15:0]));
            n_errors++;
          end
          if (out_tdata[40:16] !== want.level) begin
            $error("envelope_level: expected %0d, actual %0d", want.level, out_tdata[40:16]);
            n_errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idling_on() && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push(input logic gate, input logic [SAMPLE_BITS-1:0] noise);
    sample_req_t r;
    r.gate  = gate;
    r.noise = noise;
    pending_q.push_back(r);
    n_queued++;
  endtask

  task automatic drain();
    while (n_accepted != n_queued || expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that back-to-back writes never lower and raise it
  // in the same step; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ATTACK_POLE:  atk_pole = val;
      CFG_RELEASE_POLE: rel_pole = val;
      CFG_OVERSHOOT:    ovs = val[OVS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [23:0] a, input logic [23:0] r, input logic [23:0] o);
    write_reg(CFG_ATTACK_POLE, a);
    write_reg(CFG_RELEASE_POLE, r);
    write_reg(CFG_OVERSHOOT, o);
    write_reg(CFG_UNUSED, 24'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_noise();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_pole();
    case ($urandom_range(0, 4))
      0: return 24'h000000;
      1: return 24'hffffff;
      2: return 24'($urandom);
      default: return 24'($urandom_range(24'he00000, 24'hfff000));
    endcase
  endfunction

  function automatic logic [23:0] pick_overshoot();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'd1048576;
      2: return 24'h1fffff;
      3: return 24'($urandom);
      default: return 24'($urandom_range(0, 65536));
    endcase
  endfunction

  // Mostly held and released gate runs with random noise, some scrambled gates.
  task automatic queue_bursts(input int n_items);
    int stop;
    int len;
    stop = n_queued + n_items;
    while (n_queued < stop) begin
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len && n_queued < stop; i++) begin
          push(1'($urandom_range(0, 1)), pick_noise());
        end
      end else begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 30);
        for (int i = 0; i < len && n_queued < stop; i++) push(1'b1, pick_noise());
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 30);
        for (int i = 0; i < len && n_queued < stop; i++) push(1'b0, pick_noise());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Idle ticks, then an attack and release at reset settings.
    push(1'b0, 16'h0000);
    push(1'b0, 16'h8000);
    push(1'b0, 16'h7fff);
    push(1'b1, 16'h7fff);
    push(1'b1, 16'h8000);
    push(1'b1, 16'h0000);
    push(1'b1, 16'h5555);
    push(1'b1, 16'haaaa);
    push(1'b1, 16'h7fff);
    push(1'b0, 16'h7fff);
    push(1'b0, 16'h8000);
    push(1'b0, 16'h0001);
    push(1'b1, 16'hffff);
    push(1'b0, 16'hffff);
    push(1'b0, 16'h7fff);
    push(1'b1, 16'h8000);
    drain();

    // Zero poles with the widest overshoot end attack and release in one step.
    write_all(24'h000000, 24'h000000, 24'hffffff);
    push(1'b1, 16'h7fff);
    push(1'b1, 16'h8000);
    push(1'b1, 16'h7fff);
    push(1'b0, 16'h8000);
    push(1'b1, 16'h8000);
    push(1'b0, 16'h7fff);
    push(1'b0, 16'h0000);
    drain();

    for (int k = 0; k < 8; k++) begin
      if (k == 0) write_all(24'hffffff, 24'h000000, 24'd0);
      else if (k == 1) write_all(24'h000000, 24'hffffff, 24'd1048576);
      else if (k == 2) write_all(24'($urandom_range(24'hc00000, 24'hfff000)),
                                 24'($urandom_range(24'hc00000, 24'hfff000)), 24'd0);
      else write_all(pick_pole(), pick_pole(), pick_overshoot());
      if (k == 7) quiet = 1'b1;
      queue_bursts(115);
      drain();
    end

    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
src/arnb_pkg.sv
src/arnb_ctrl.sv
src/arnb_dp.sv
src/attack_release_noise_burst_unit.sv
test/tb_top.sv
